// File: src/free_extent_allocator_unit_macros.svh
// Assertion helpers for the free extent allocator.
`ifndef FREE_EXTENT_ALLOCATOR_UNIT_MACROS_SVH
`define FREE_EXTENT_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define FEA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define FEA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/fea_pkg.sv
package fea_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_ARG      = 3'd1,
    STAT_OVERLAP  = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_NOFIT    = 3'd4,
    STAT_FULL     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  localparam logic REG_COALESCE = 1'b0;
  localparam logic REG_SPLIT    = 1'b1;

  typedef struct packed {
    logic [31:0] start;
    logic [15:0] count;
    logic [31:0] age;
  } entry_t;

  typedef struct packed {
    logic wr_en;
    logic vld_set;
    logic vld_clr;
    logic clr_all;
  } tbl_ctl_t;

endpackage

// File: src/fea_table.sv
module fea_table import fea_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tbl_ctl_t      ctl,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] clr_addr,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  output logic          rd_vld
);

  entry_t mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  entry_t rd_data_r;
  logic   rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= valid_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr_all) begin
      valid_r <= '0;
    end else begin
      if (ctl.vld_clr) valid_r[clr_addr] <= 1'b0;
      if (ctl.wr_en && ctl.vld_set) valid_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;
  assign rd_vld  = rd_vld_r;

endmodule

// File: src/fea_ctrl.sv
module fea_ctrl import fea_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int CW = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    op,
  input  logic [31:0]   blk_start,
  input  logic [15:0]   blk_count,
  input  logic          suballoc,
  input  logic          coalesce_en,
  input  logic [15:0]   split_thr,
  output tbl_ctl_t      ctl,
  output logic [AW-1:0] wr_addr,
  output entry_t        wr_data,
  output logic [AW-1:0] clr_addr,
  output logic [AW-1:0] rd_addr,
  input  entry_t        rd_data,
  input  logic          rd_vld,
  output logic          out_valid,
  output logic          out_success,
  output logic [2:0]    out_status,
  output logic [31:0]   out_result_start,
  output logic [15:0]   out_result_count
);

  localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES);

  state_t state_r, state_nxt;
  logic [CW-1:0] issue_r;
  logic          p_vld_r;
  logic [AW-1:0] p_idx_r;
  logic [31:0]   age_r;

  opcode_t     op_r;
  logic [31:0] s_r;
  logic [15:0] c_r;
  logic        sub_r;

  // best match (alloc) or exact match (release)
  logic          found_r;
  logic [AW-1:0] best_idx_r;
  logic [15:0]   best_cnt_r;
  logic [31:0]   best_dist_r;
  logic [31:0]   best_start_r;
  logic [15:0]   closest_r;

  // free neighbors
  logic          ovl_r;
  logic          empty_f_r;
  logic [AW-1:0] empty_idx_r;
  logic          next_f_r;
  logic [AW-1:0] next_idx_r;
  logic [31:0]   next_start_r;
  logic [15:0]   next_cnt_r;
  logic          prev_f_r;
  logic [AW-1:0] prev_idx_r;
  logic [31:0]   prev_start_r;
  logic [15:0]   prev_cnt_r;

  logic        out_valid_r, out_success_r;
  logic [2:0]  out_status_r;
  logic [31:0] out_start_r;
  logic [15:0] out_count_r;

  // shared per-entry compare unit
  logic [17:0] need;
  logic        fits, take_alloc, ovl_e;
  logic [31:0] age_gap;
  logic [32:0] req_end, ent_end;

  always_comb begin
    need       = {2'b0, c_r} + {2'b0, split_thr} + 18'd1;
    fits       = (rd_data.count >= c_r) &&
                 ((rd_data.count == c_r) ||
                  ((need <= 18'h0FFFF) && ({2'b0, rd_data.count} >= need)));
    age_gap    = age_r - rd_data.age;
    take_alloc = rd_vld && fits &&
                 (!found_r || (rd_data.count < best_cnt_r) ||
                  ((rd_data.count == best_cnt_r) && (age_gap > best_dist_r)));
    req_end    = {1'b0, s_r} + {17'b0, c_r};
    ent_end    = {1'b0, rd_data.start} + {17'b0, rd_data.count};
    ovl_e      = ({1'b0, rd_data.start} < req_end) && ({1'b0, s_r} < ent_end);
  end

  // finish step
  logic [16:0] nsum, psum;
  logic [32:0] prev_end;
  logic        with_next, with_prev, stamp;
  logic [15:0] total;
  logic        fin_ok;
  status_t     fin_st;
  logic [31:0] fin_start;
  logic [15:0] fin_count;
  tbl_ctl_t    ctl_c;

  always_comb begin
    nsum      = {1'b0, c_r} + {1'b0, next_cnt_r};
    with_next = coalesce_en && next_f_r && (req_end == {1'b0, next_start_r}) && !nsum[16];
    total     = with_next ? nsum[15:0] : c_r;
    psum      = {1'b0, total} + {1'b0, prev_cnt_r};
    prev_end  = {1'b0, prev_start_r} + {17'b0, prev_cnt_r};
    with_prev = coalesce_en && prev_f_r && (prev_end == {1'b0, s_r}) && !psum[16];

    ctl_c     = '0;
    stamp     = 1'b0;
    wr_addr   = best_idx_r;
    clr_addr  = best_idx_r;
    wr_data   = '{start: best_start_r + s_r, count: best_cnt_r - c_r, age: age_r};
    fin_ok    = 1'b0;
    fin_st    = STAT_OK;
    fin_start = '0;
    fin_count = '0;

    unique case (op_r)
      OP_ALLOC: begin
        if (c_r == 16'd0) begin
          fin_st = STAT_ARG;
        end else if (!found_r) begin
          fin_st    = STAT_NOFIT;
          fin_count = closest_r;
        end else begin
          fin_ok    = 1'b1;
          fin_start = best_start_r;
          fin_count = c_r;
          wr_data.start = best_start_r + {16'b0, c_r};
          if (best_cnt_r == c_r) begin
            ctl_c.vld_clr = 1'b1;
          end else begin
            ctl_c.wr_en = 1'b1;
            stamp       = 1'b1;
          end
        end
      end
      OP_FREE: begin
        if ((c_r == 16'd0) || sub_r) begin
          fin_st = STAT_ARG;
        end else if (ovl_r) begin
          fin_st = STAT_OVERLAP;
        end else if (!with_prev && !with_next && !empty_f_r) begin
          fin_st = STAT_FULL;
        end else if (with_prev) begin
          fin_ok        = 1'b1;
          ctl_c.wr_en   = 1'b1;
          stamp         = 1'b1;
          wr_addr       = prev_idx_r;
          wr_data       = '{start: prev_start_r, count: psum[15:0], age: age_r};
          ctl_c.vld_clr = with_next;
          clr_addr      = next_idx_r;
        end else begin
          fin_ok        = 1'b1;
          ctl_c.wr_en   = 1'b1;
          ctl_c.vld_set = 1'b1;
          stamp         = 1'b1;
          wr_addr       = with_next ? next_idx_r : empty_idx_r;
          wr_data       = '{start: s_r, count: total, age: age_r};
        end
      end
      OP_RELEASE: begin
        if (found_r) begin
          fin_ok        = 1'b1;
          ctl_c.vld_clr = 1'b1;
        end else begin
          fin_st = STAT_NOTFOUND;
        end
      end
      OP_CLEAR: begin
        fin_ok        = 1'b1;
        ctl_c.clr_all = 1'b1;
      end
      default: ;
    endcase

    ctl = (state_r == ST_FINISH) ? ctl_c : '0;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (opcode_t'(op) == OP_CLEAR) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((issue_r == LAST) && !p_vld_r) state_nxt = ST_FINISH;
      end
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  assign busy    = (state_r != ST_IDLE);
  assign rd_addr = issue_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_r     <= '0;
      p_vld_r     <= 1'b0;
      age_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_FINISH);
      if ((state_r == ST_FINISH) && stamp) age_r <= age_r + 32'd1;
      if (state_r == ST_IDLE) begin
        issue_r <= '0;
        p_vld_r <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        p_vld_r <= (issue_r != LAST);
        if (issue_r != LAST) issue_r <= issue_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      op_r      <= opcode_t'(op);
      s_r       <= blk_start;
      c_r       <= blk_count;
      sub_r     <= suballoc;
      found_r   <= 1'b0;
      closest_r <= '0;
      ovl_r     <= 1'b0;
      empty_f_r <= 1'b0;
      next_f_r  <= 1'b0;
      prev_f_r  <= 1'b0;
    end
    if (state_r == ST_SCAN) begin
      p_idx_r <= issue_r[AW-1:0];
    end
    if (state_r == ST_SCAN && p_vld_r) begin
      unique case (op_r)
        OP_ALLOC: begin
          if (rd_vld && (rd_data.count < c_r) && (rd_data.count > closest_r)) begin
            closest_r <= rd_data.count;
          end
          if (take_alloc) begin
            found_r      <= 1'b1;
            best_idx_r   <= p_idx_r;
            best_cnt_r   <= rd_data.count;
            best_dist_r  <= age_gap;
            best_start_r <= rd_data.start;
          end
        end
        OP_FREE: begin
          if (!rd_vld) begin
            if (!empty_f_r) begin
              empty_f_r   <= 1'b1;
              empty_idx_r <= p_idx_r;
            end
          end else begin
            if (ovl_e) ovl_r <= 1'b1;
            if (rd_data.start > s_r) begin
              if (!next_f_r || (rd_data.start < next_start_r)) begin
                next_f_r     <= 1'b1;
                next_idx_r   <= p_idx_r;
                next_start_r <= rd_data.start;
                next_cnt_r   <= rd_data.count;
              end
            end else if (!prev_f_r || (rd_data.start > prev_start_r)) begin
              prev_f_r     <= 1'b1;
              prev_idx_r   <= p_idx_r;
              prev_start_r <= rd_data.start;
              prev_cnt_r   <= rd_data.count;
            end
          end
        end
        OP_RELEASE: begin
          if (rd_vld && !found_r && (rd_data.start == s_r) && (rd_data.count == c_r)) begin
            found_r    <= 1'b1;
            best_idx_r <= p_idx_r;
          end
        end
        OP_CLEAR: ;
        default: ;
      endcase
    end
    if (state_r == ST_FINISH) begin
      out_success_r <= fin_ok;
      out_status_r  <= fin_st;
      out_start_r   <= fin_start;
      out_count_r   <= fin_count;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_success      = out_success_r;
  assign out_status       = out_status_r;
  assign out_result_start = out_start_r;
  assign out_result_count = out_count_r;

endmodule

// File: src/free_extent_allocator_unit.sv
// Best-fit free extent allocator. A request is taken when start is high and busy is low;
// its result appears on the out_ ports for exactly one cycle with out_valid high, and the
// receiver cannot stall it. Alloc, free and release scan the whole table through a single
// read port, one entry per cycle, before the result strobe; clear skips the scan and goes
// straight to the finish step. busy stays high until the result is issued.
// Configuration over the APB port: coalesce_enable at byte 0, split_threshold at byte 4.
`include "free_extent_allocator_unit_macros.svh"

module free_extent_allocator_unit import fea_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_block_start,
  input  logic [15:0] in_block_count,
  input  logic        in_suballoc_flag,
  output logic        out_valid,
  output logic        out_success,
  output logic [2:0]  out_status,
  output logic [31:0] out_result_start,
  output logic [15:0] out_result_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic        coal_r;
  logic [15:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coal_r <= 1'b1;
      thr_r  <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_COALESCE) coal_r <= pwdata[0];
      else                          thr_r  <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SPLIT) ? {16'b0, thr_r} : {31'b0, coal_r};

  tbl_ctl_t      ctl;
  logic [AW-1:0] wr_addr, clr_addr, rd_addr;
  entry_t        wr_data, rd_data;
  logic          rd_vld;

  fea_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
    .clk, .rst_n, .ctl, .wr_addr, .wr_data, .clr_addr, .rd_addr, .rd_data, .rd_vld
  );

  fea_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk, .rst_n, .start, .busy,
    .op(in_opcode), .blk_start(in_block_start), .blk_count(in_block_count),
    .suballoc(in_suballoc_flag), .coalesce_en(coal_r), .split_thr(thr_r),
    .ctl, .wr_addr, .wr_data, .clr_addr, .rd_addr, .rd_data, .rd_vld,
    .out_valid, .out_success, .out_status, .out_result_start, .out_result_count
  );

  `FEA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `FEA_ASSERT_IMPLY(a_out_idle, out_valid, !busy)
  `FEA_ASSERT_IMPLY(a_ok_status, out_valid, out_success == (out_status == STAT_OK))
  `FEA_ASSERT_IMPLY(a_fail_start, out_valid && !out_success, out_result_start == 32'd0)

endmodule

// File: tb/free_extent_allocator_unit_tb.sv
module free_extent_allocator_unit_tb;
  import fea_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic        success;
    status_t     status;
    logic [31:0] rstart;
    logic [15:0] rcount;
  } outcome_t;

  // Predictor of the extent table and its expected outcomes.
  class extent_board;
    bit          valid_q[N_ENTRIES];
    bit   [31:0] base_q[N_ENTRIES];
    bit   [15:0] size_q[N_ENTRIES];
    bit   [31:0] stamp_q[N_ENTRIES];
    bit   [31:0] age_ctr;
    bit          merge_en;
    bit   [15:0] split_thr;
    outcome_t    pending[$];
    int          errors;

    function void init();
      foreach (valid_q[i]) valid_q[i] = 0;
      age_ctr = 0;
      merge_en = 1;
      split_thr = 0;
      errors = 0;
    endfunction

    function void restamp(int i);
      stamp_q[i] = age_ctr;
      age_ctr++;
    endfunction

    function outcome_t mk(bit ok, status_t st, bit [31:0] s, bit [15:0] c);
      outcome_t o;
      o.success = ok; o.status = st; o.rstart = s; o.rcount = c;
      return o;
    endfunction

    function outcome_t alloc(bit [15:0] req);
      int best;
      bit [31:0] best_dist, d;
      bit [15:0] closest;
      bit [16:0] need;
      outcome_t o;
      best = -1; best_dist = 0; closest = 0;
      need = {1'b0, req} + {1'b0, split_thr} + 17'd1;
      if (req == 0) return mk(0, STAT_ARG, 0, 0);
      for (int i = 0; i < N_ENTRIES; i++) begin
        if (!valid_q[i]) continue;
        if (size_q[i] < req) begin
          if (size_q[i] > closest) closest = size_q[i];
          continue;
        end
        if (size_q[i] != req && (need > 17'hFFFF || size_q[i] < need)) continue;
        d = age_ctr - stamp_q[i];
        if (best < 0 || size_q[i] < size_q[best] ||
            (size_q[i] == size_q[best] && d > best_dist)) begin
          best = i;
          best_dist = d;
        end
      end
      if (best < 0) return mk(0, STAT_NOFIT, 0, closest);
      o = mk(1, STAT_OK, base_q[best], req);
      if (size_q[best] == req) valid_q[best] = 0;
      else begin
        size_q[best] -= req;
        base_q[best] += req;
        restamp(best);
      end
      return o;
    endfunction

    function outcome_t free_ext(bit [31:0] s, bit [15:0] c, bit sub);
      int nxt, prv, empty;
      bit [32:0] e;
      bit [16:0] total;
      bit wn, wp;
      nxt = -1; prv = -1; empty = -1;
      e = {1'b0, s} + c;
      total = c; wn = 0; wp = 0;
      if (c == 0 || sub) return mk(0, STAT_ARG, 0, 0);
      for (int i = 0; i < N_ENTRIES; i++) begin
        if (!valid_q[i]) begin
          if (empty < 0) empty = i;
          continue;
        end
        if ({1'b0, base_q[i]} < e && {1'b0, s} < {1'b0, base_q[i]} + size_q[i])
          return mk(0, STAT_OVERLAP, 0, 0);
        if (base_q[i] > s) begin
          if (nxt < 0 || base_q[i] < base_q[nxt]) nxt = i;
        end else begin
          if (prv < 0 || base_q[i] > base_q[prv]) prv = i;
        end
      end
      if (merge_en) begin
        if (nxt >= 0 && e == {1'b0, base_q[nxt]} && total + size_q[nxt] <= 17'hFFFF) begin
          total += size_q[nxt];
          wn = 1;
        end
        if (prv >= 0 && {1'b0, base_q[prv]} + size_q[prv] == {1'b0, s} &&
            total + size_q[prv] <= 17'hFFFF)
          wp = 1;
      end
      if (!wp && !wn && empty < 0) return mk(0, STAT_FULL, 0, 0);
      if (wp) begin
        size_q[prv] += total[15:0];
        restamp(prv);
        if (wn) valid_q[nxt] = 0;
      end else begin
        int slot;
        slot = wn ? nxt : empty;
        valid_q[slot] = 1;
        base_q[slot] = s;
        size_q[slot] = total[15:0];
        restamp(slot);
      end
      return mk(1, STAT_OK, 0, 0);
    endfunction

    function void note_request(opcode_t op, bit [31:0] s, bit [15:0] c, bit sub);
      outcome_t o;
      case (op)
        OP_ALLOC: o = alloc(c);
        OP_FREE: o = free_ext(s, c, sub);
        OP_RELEASE: begin
          o = mk(0, STAT_NOTFOUND, 0, 0);
          for (int i = 0; i < N_ENTRIES; i++)
            if (valid_q[i] && base_q[i] == s && size_q[i] == c) begin
              valid_q[i] = 0;
              o = mk(1, STAT_OK, 0, 0);
              break;
            end
        end
        default: begin
          foreach (valid_q[i]) valid_q[i] = 0;
          o = mk(1, STAT_OK, 0, 0);
        end
      endcase
      pending.push_back(o);
    endfunction

    function void check_result(outcome_t got);
      outcome_t w;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.success !== w.success) begin
        $error("success: expected %0d actual %0d", w.success, got.success); errors++;
      end
      if (got.status !== w.status) begin
        $error("status: expected %0d actual %0d", w.status, got.status); errors++;
      end
      if (got.rstart !== w.rstart) begin
        $error("result_start: expected %0h actual %0h", w.rstart, got.rstart); errors++;
      end
      if (got.rcount !== w.rcount) begin
        $error("result_count: expected %0d actual %0d", w.rcount, got.rcount); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy;
  logic [1:0] in_opcode;
  logic [31:0] in_block_start;
  logic [15:0] in_block_count;
  logic in_suballoc_flag;
  logic out_valid, out_success;
  logic [2:0] out_status;
  logic [31:0] out_result_start;
  logic [15:0] out_result_count;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  extent_board board;
  int idle_cycles;
  bit [31:0] extent_base;

  free_extent_allocator_unit dut (.*);

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check_result({out_success, status_t'(out_status), out_result_start,
                          out_result_count});
    if ((start && !busy) || out_valid || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("free_extent_allocator_unit: mismatch");
      $finish;
    end
  end

  task automatic pause(int n);
    repeat (n) @(posedge clk);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  // start stays high into a back-to-back request; busy masks it meanwhile
  task automatic send_request(opcode_t op, bit [31:0] s, bit [15:0] c, bit sub);
    int g;
    start <= 1'b1;
    in_opcode <= op;
    in_block_start <= s;
    in_block_count <= c;
    in_suballoc_flag <= sub;
    do @(posedge clk); while (busy);
    board.note_request(op, s, c, sub);
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      pause(g);
    end
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    start <= 1'b0;
    // let any outstanding request drain before touching config
    while (board.pending.size() != 0) @(posedge clk);
    pause(4);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd0) board.merge_en = data[0];
    else if (addr == 3'd4) board.split_thr = data[15:0];
    @(posedge clk);
  endtask

  // Mostly near-by extents so frees coalesce and allocs hit; some noise.
  task automatic random_request();
    int r;
    bit [31:0] s;
    bit [15:0] c;
    r = $urandom_range(0, 99);
    c = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 40));
    s = extent_base + $urandom_range(0, 600);
    if ($urandom_range(0, 19) == 0) s = $urandom();
    if (r < 40) send_request(OP_ALLOC, $urandom(), c, 1'($urandom_range(0, 1)));
    else if (r < 85)
      send_request(OP_FREE, s, c, $urandom_range(0, 15) == 0);
    else if (r < 98) begin
      int k;
      k = $urandom_range(0, N_ENTRIES - 1);
      if (board.valid_q[k] && $urandom_range(0, 1))
        send_request(OP_RELEASE, board.base_q[k], board.size_q[k],
                     1'($urandom_range(0, 1)));
      else send_request(OP_RELEASE, s, c, 1'($urandom_range(0, 1)));
    end else send_request(OP_CLEAR, $urandom(), 16'($urandom()), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    board = new();
    board.init();
    idle_cycles = 0;
    extent_base = 32'h1000;
    rst_n = 1'b0; start = 1'b0;
    in_opcode = OP_ALLOC; in_block_start = '0; in_block_count = '0; in_suballoc_flag = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    pause(3);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_request(OP_ALLOC, 0, 0, 0);
    send_request(OP_ALLOC, 0, 16'hFFFF, 0);
    send_request(OP_FREE, 32'h100, 0, 0);
    send_request(OP_FREE, 32'h100, 10, 1);
    send_request(OP_FREE, 32'hFFFF_FFF0, 16'hFFFF, 0);
    send_request(OP_FREE, 32'hFFFF_FFFF, 1, 0);
    send_request(OP_FREE, 32'h100, 10, 0);
    send_request(OP_FREE, 32'h10A, 10, 0);
    send_request(OP_FREE, 32'hF6, 10, 0);
    send_request(OP_FREE, 32'h104, 2, 0);
    send_request(OP_FREE, 32'h200, 16'hFFF0, 0);
    send_request(OP_FREE, 32'h200 + 32'hFFF0, 20, 0);
    send_request(OP_ALLOC, 0, 5, 0);
    send_request(OP_ALLOC, 0, 16'hFFFF, 0);
    send_request(OP_RELEASE, 32'h100, 1, 0);
    send_request(OP_RELEASE, 32'h200, 16'hFFF0, 0);
    send_request(OP_RELEASE, 0, 0, 0);
    send_request(OP_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 1);
    write_reg(3'd0, 32'h0);
    write_reg(3'd4, 32'hFFFF);
    for (int i = 0; i < N_ENTRIES + 1; i++)
      send_request(OP_FREE, 32'h10 * i, 16'h10, 0);
    send_request(OP_ALLOC, 0, 16, 0);
    send_request(OP_ALLOC, 0, 15, 0);
    send_request(OP_CLEAR, 0, 0, 0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(3'd0, 32'h1); write_reg(3'd4, 32'h0); end
        1: write_reg(3'd4, 32'h3);
        2: begin write_reg(3'd0, 32'hFFFF_FFFE); write_reg(3'd4, 32'h1_0008); end
        3: write_reg(3'd4, 32'hFFFF);
        4: begin write_reg(3'd0, 32'hFFFF_FFFF); write_reg(3'd4, 32'hFFFF_0000); end
        default: write_reg(3'd4, $urandom_range(0, 20));
      endcase
      extent_base = $urandom();
      for (int n = 0; n < 215; n++) random_request();
    end

    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    pause(80);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("free_extent_allocator_unit: match");
    else
      $display("free_extent_allocator_unit: mismatch");
    $finish;
  end
endmodule
